// ----- hw/rtl/dmic_pkg.sv -----
`timescale 1ns / 1ps

package dmic_pkg;

  localparam int WORD_BITS    = 32;
  localparam int PORT_WORDS   = 8;
  localparam int STALL_BITS   = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [STALL_BITS-1:0] MISS_PENALTY_RESET = 8'd15;

  // One fetch request as it arrives on the input port
  typedef struct packed {
    logic [WORD_BITS-1:0] fetch_addr;
    logic [WORD_BITS-1:0] fill_word_0;
    logic [WORD_BITS-1:0] fill_word_1;
    logic [WORD_BITS-1:0] fill_word_2;
    logic [WORD_BITS-1:0] fill_word_3;
    logic [WORD_BITS-1:0] fill_word_4;
    logic [WORD_BITS-1:0] fill_word_5;
    logic [WORD_BITS-1:0] fill_word_6;
    logic [WORD_BITS-1:0] fill_word_7;
  } fetch_req_t;

  // One fetch response as it leaves on the result port
  typedef struct packed {
    logic [WORD_BITS-1:0]  line_word_0;
    logic [WORD_BITS-1:0]  line_word_1;
    logic [WORD_BITS-1:0]  line_word_2;
    logic [WORD_BITS-1:0]  line_word_3;
    logic [WORD_BITS-1:0]  line_word_4;
    logic [WORD_BITS-1:0]  line_word_5;
    logic [WORD_BITS-1:0]  line_word_6;
    logic [WORD_BITS-1:0]  line_word_7;
    logic                  was_hit;
    logic [STALL_BITS-1:0] stall_cycles;
  } fetch_rsp_t;

  // Classified fetch handed from lookup to the data side
  typedef struct packed {
    fetch_req_t            req;
    logic                  hit;
    logic [STALL_BITS-1:0] stall;
  } icq_entry_t;

  typedef logic [PORT_WORDS-1:0][WORD_BITS-1:0] word_array_t;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_LOOKUP
  } front_state_t;

  // Gather the fill words of a request into an array
  function automatic word_array_t fill_words(fetch_req_t r);
    word_array_t w;
    w[0] = r.fill_word_0;
    w[1] = r.fill_word_1;
    w[2] = r.fill_word_2;
    w[3] = r.fill_word_3;
    w[4] = r.fill_word_4;
    w[5] = r.fill_word_5;
    w[6] = r.fill_word_6;
    w[7] = r.fill_word_7;
    return w;
  endfunction

  // Build a response from a line and its status
  function automatic fetch_rsp_t make_rsp(word_array_t w, logic hit,
                                          logic [STALL_BITS-1:0] stall);
    fetch_rsp_t r;
    r.line_word_0  = w[0];
    r.line_word_1  = w[1];
    r.line_word_2  = w[2];
    r.line_word_3  = w[3];
    r.line_word_4  = w[4];
    r.line_word_5  = w[5];
    r.line_word_6  = w[6];
    r.line_word_7  = w[7];
    r.was_hit      = hit;
    r.stall_cycles = stall;
    return r;
  endfunction

endpackage

// ----- hw/rtl/dmic_front.sv -----
`timescale 1ns / 1ps

module dmic_front import dmic_pkg::*; #(
  parameter int INDEX_BITS  = 5,
  parameter int OFFSET_BITS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  fetch_req_t            req,
  input  logic [STALL_BITS-1:0] miss_penalty,
  output logic                  push_valid,
  input  logic                  push_ready,
  output icq_entry_t            push_entry
);

  localparam int NUM_LINES = 1 << INDEX_BITS;
  localparam int TAG_LSB   = OFFSET_BITS + INDEX_BITS;
  localparam int TAG_BITS  = WORD_BITS - TAG_LSB;
  localparam logic [INDEX_BITS-1:0] LAST_IDX = {INDEX_BITS{1'b1}};

  front_state_t state, state_next;
  logic [INDEX_BITS-1:0] clr_idx, clr_idx_next;

  // Tag RAM entry: valid bit over tag
  logic [TAG_BITS:0] tag_mem [NUM_LINES];
  logic [TAG_BITS:0] tag_rd;
  fetch_req_t        s1_req;

  logic                  accept;
  logic                  hit;
  logic                  tag_we;
  logic [INDEX_BITS-1:0] tag_waddr;
  logic [TAG_BITS:0]     tag_wdata;
  logic [INDEX_BITS-1:0] req_idx;
  logic [INDEX_BITS-1:0] s1_idx;
  logic [TAG_BITS-1:0]   s1_tag;

  assign req_idx = req.fetch_addr[OFFSET_BITS +: INDEX_BITS];
  assign s1_idx  = s1_req.fetch_addr[OFFSET_BITS +: INDEX_BITS];
  assign s1_tag  = s1_req.fetch_addr[TAG_LSB +: TAG_BITS];
  assign hit     = tag_rd[TAG_BITS] && (tag_rd[TAG_BITS-1:0] == s1_tag);

  // Advance state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FS_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  assign clr_idx_next = (state == FS_CLEAR) ? clr_idx + 1'b1 : clr_idx;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_CLEAR:  if (clr_idx == LAST_IDX) state_next = FS_IDLE;
      FS_IDLE:   if (start) state_next = FS_LOOKUP;
      FS_LOOKUP: if (push_ready) state_next = FS_IDLE;
      default:   state_next = FS_CLEAR;
    endcase
  end

  // Decode outputs and tag RAM controls
  always_comb begin
    busy      = 1'b1;
    accept    = 1'b0;
    push_valid = 1'b0;
    tag_we    = 1'b0;
    tag_waddr = s1_idx;
    tag_wdata = {1'b1, s1_tag};
    unique case (state)
      FS_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx;
        tag_wdata = '0;
      end
      FS_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      FS_LOOKUP: begin
        push_valid = 1'b1;
        tag_we     = push_ready && !hit;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Tag RAM write, registered read and request capture
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (accept) begin
      tag_rd <= tag_mem[req_idx];
      s1_req <= req;
    end
  end

  assign push_entry.req   = s1_req;
  assign push_entry.hit   = hit;
  assign push_entry.stall = hit ? '0 : miss_penalty;

endmodule

// ----- hw/rtl/dmic_queue.sv -----
`timescale 1ns / 1ps

module dmic_queue import dmic_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  icq_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output icq_entry_t pop_entry
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  icq_entry_t            slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [PTR_BITS:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != QUEUE_DEPTH[PTR_BITS:0]);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/dmic_back.sv -----
`timescale 1ns / 1ps

module dmic_back import dmic_pkg::*; #(
  parameter int INDEX_BITS  = 5,
  parameter int OFFSET_BITS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  icq_entry_t pop_entry,
  output logic       done,
  output fetch_rsp_t rsp
);

  localparam int NUM_LINES  = 1 << INDEX_BITS;
  localparam int LINE_WORDS = 1 << OFFSET_BITS;

  typedef logic [LINE_WORDS-1:0][WORD_BITS-1:0] line_t;

  line_t                 data_mem [NUM_LINES];
  line_t                 rd_line;
  line_t                 fill_reg;
  line_t                 fill_line;
  logic                  out_valid;
  logic                  out_hit;
  logic [STALL_BITS-1:0] out_stall;
  logic [INDEX_BITS-1:0] pop_idx;
  word_array_t           all_fill;
  word_array_t           rsp_words;

  assign pop_ready = 1'b1;
  assign pop_idx   = pop_entry.req.fetch_addr[OFFSET_BITS +: INDEX_BITS];
  assign all_fill  = fill_words(pop_entry.req);

  // Keep only the words that fit in a line
  always_comb begin
    for (int w = 0; w < LINE_WORDS; w++) begin
      fill_line[w] = all_fill[w];
    end
  end

  // Write the line on a miss, read it on a hit
  always_ff @(posedge clk) begin
    if (pop_valid) begin
      if (pop_entry.hit) begin
        rd_line <= data_mem[pop_idx];
      end else begin
        data_mem[pop_idx] <= fill_line;
      end
      fill_reg  <= fill_line;
      out_hit   <= pop_entry.hit;
      out_stall <= pop_entry.stall;
    end
  end

  // Strobe one result per transaction taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pop_valid;
    end
  end

  // Select line source; words past the line read as zero
  for (genvar w = 0; w < PORT_WORDS; w++) begin : g_word
    if (w < LINE_WORDS) begin : g_in
      assign rsp_words[w] = out_hit ? rd_line[w] : fill_reg[w];
    end else begin : g_out
      assign rsp_words[w] = '0;
    end
  end

  assign done = out_valid;
  assign rsp  = make_rsp(rsp_words, out_hit, out_stall);

endmodule

// ----- hw/rtl/direct_mapped_icache_top.sv -----
`timescale 1ns / 1ps
// Path: an accepted fetch passes through the tag RAM read, the tag compare and
// queue push, and the data RAM read or fill before the result strobe.
// The lookup side takes a new fetch only after the tag RAM read, compare and
// tag update of the last one, and holds while the queue is full. The receiver cannot stall.
// Reset: a clearing pass over all 2**INDEX_BITS lines (32 by default) zeroes
// the valid bits while busy stays high; configuration writes are taken throughout.

module direct_mapped_icache_top import dmic_pkg::*; #(
  parameter int INDEX_BITS  = 5,
  parameter int OFFSET_BITS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  fetch_req_t            req,
  output logic                  done,
  output fetch_rsp_t            rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [STALL_BITS-1:0] cfg_data
);

  logic [STALL_BITS-1:0] miss_penalty;
  logic                  push_valid;
  logic                  push_ready;
  icq_entry_t            push_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  icq_entry_t            pop_entry;

  // Hold the miss penalty register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_penalty <= MISS_PENALTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      miss_penalty <= cfg_data;
    end
  end

  dmic_front #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .miss_penalty (miss_penalty),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  dmic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  dmic_back #(
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
